[rtl/nameq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package nameq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	// wide enough for position, count + 1 and cell indexes side by side
	localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

	typedef enum logic [2:0] {
		ACT_PUSH   = 3'd0,
		ACT_POP    = 3'd1,
		ACT_SEARCH = 3'd2,
		ACT_DELETE = 3'd3,
		ACT_INSERT = 3'd4
	} action_e;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		SEL_HOLD = 2'd0,
		SEL_NEXT = 2'd1,
		SEL_PREV = 2'd2,
		SEL_NEW  = 2'd3
	} cell_sel_e;

	typedef struct packed {
		logic [55:0] front;
		logic [55:0] back;
	} name_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [55:0] name_front;
		logic [55:0] name_back;
		logic [4:0]  position;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [4:0]  found_position;
		logic [55:0] head_front;
		logic [55:0] head_back;
		logic [4:0]  occupancy;
		logic [1:0]  status;
	} rsp_t;

endpackage

`default_nettype wire

[rtl/nameq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module nameq_cell
	import nameq_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_sel_e sel,
	input  wire name_t     prev_name,
	input  wire name_t     next_name,
	input  wire name_t     new_name,
	input  wire name_t     key,
	output name_t          name_q,
	output name_t          name_d,
	output logic           match
);

	always_comb begin
		case (sel)
			SEL_NEXT: name_d = next_name;
			SEL_PREV: name_d = prev_name;
			SEL_NEW:  name_d = new_name;
			default:  name_d = name_q;
		endcase
	end

	always_ff @(posedge clk) begin
		name_q <= name_d;
	end

	assign match = (name_q == key);

endmodule

`default_nettype wire

[rtl/name_queue_with_search_insert_delete.sv]
// Ordered queue of up to DEPTH 14-byte names held in a row of cells, slot 0 at the head.
// For each request beat (push, pop, search, delete at or insert at a 1-based position)
// every cell compares its name against the key and shifts toward or away from the
// head in parallel, and the response beat appears from the response register on the
// cycle after acceptance. One beat per cycle is sustained; the request side stalls
// only while an untaken response sits in that register. A search also reports found and position.
// Each response reports the head name and occupancy after the step, plus status.
`timescale 1ns / 1ps
`default_nettype none

module name_queue_with_search_insert_delete
	import nameq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_d;
	logic             accept;

	name_t            cell_q [DEPTH];
	name_t            cell_d [DEPTH];
	cell_sel_e        cell_sel [DEPTH];
	logic [DEPTH-1:0] cell_match;
	name_t            key;

	logic             do_insert;
	logic             do_remove;
	logic [CMP_W-1:0] idx;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic             full;
	logic             empty;

	assign accept    = req_valid && !req_stall;
	assign req_stall = rsp_valid_q && rsp_stall;
	assign key.front = req.name_front;
	assign key.back  = req.name_back;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		nameq_cell u_cell (
			.clk       (clk),
			.sel       (cell_sel[i]),
			.prev_name ((i == 0) ? key : cell_q[(i == 0) ? 0 : i - 1]),
			.next_name ((i == DEPTH - 1) ? cell_q[i] : cell_q[(i == DEPTH - 1) ? i : i + 1]),
			.new_name  (key),
			.key       (key),
			.name_q    (cell_q[i]),
			.name_d    (cell_d[i]),
			.match     (cell_match[i])
		);
	end

	always_comb begin
		pos_x     = CMP_W'(req.position);
		cnt_x     = CMP_W'(count_q);
		full      = (count_q == CNT_W'(DEPTH));
		empty     = (count_q == '0);
		do_insert = 1'b0;
		do_remove = 1'b0;
		idx       = '0;
		rsp_d     = '0;
		rsp_d.status = ST_OK;

		unique case (req.action)
			ACT_PUSH: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					do_insert = 1'b1;
					idx       = cnt_x;
				end
			end
			ACT_POP: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					do_remove = 1'b1;
				end
			end
			ACT_SEARCH: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					// scan from the tail so the match nearest the head wins
					for (int i = DEPTH - 1; i >= 0; i--) begin
						if (cell_match[i] && (CMP_W'(i) < cnt_x)) begin
							rsp_d.found          = 1'b1;
							rsp_d.found_position = 5'(i + 1);
						end
					end
				end
			end
			ACT_DELETE: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else if (pos_x == '0 || pos_x > cnt_x) begin
					rsp_d.status = ST_RANGE;
				end else begin
					do_remove = 1'b1;
					idx       = pos_x - CMP_W'(1);
				end
			end
			ACT_INSERT: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
					rsp_d.status = ST_RANGE;
				end else begin
					do_insert = 1'b1;
					idx       = pos_x - CMP_W'(1);
				end
			end
			default: begin
			end
		endcase

		for (int i = 0; i < DEPTH; i++) begin
			cell_sel[i] = SEL_HOLD;
			if (accept && do_remove && CMP_W'(i) >= idx) begin
				cell_sel[i] = SEL_NEXT;
			end else if (accept && do_insert && CMP_W'(i) == idx) begin
				cell_sel[i] = SEL_NEW;
			end else if (accept && do_insert && CMP_W'(i) > idx) begin
				cell_sel[i] = SEL_PREV;
			end
		end

		count_d = count_q;
		if (do_insert) begin
			count_d = count_q + CNT_W'(1);
		end else if (do_remove) begin
			count_d = count_q - CNT_W'(1);
		end

		rsp_d.occupancy  = 5'(count_d);
		rsp_d.head_front = (count_d == '0) ? '0 : cell_d[0].front;
		rsp_d.head_back  = (count_d == '0) ? '0 : cell_d[0].back;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			count_q     <= count_d;
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[rtl/nameq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module nameq_checker
	import nameq_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.occupancy == 5'(DEPTH))
		else $error("full refusal with room left");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |-> rsp.status == ST_OK && rsp.occupancy != 5'd0)
		else $error("match reported on a failed or empty step");

	a_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.found_position == 5'd0)
		else $error("position given without a match");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.occupancy == 5'd0 && DEPTH < 32
		|-> rsp.head_front == '0 && rsp.head_back == '0)
		else $error("empty queue shows a head name");

endmodule

bind name_queue_with_search_insert_delete nameq_checker u_nameq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
